/* design/bond_price_duration_convexity_defines.svh */
// Assertion macros for the bond pricing block.
`ifndef BOND_PRICE_DURATION_CONVEXITY_DEFINES_SVH
`define BOND_PRICE_DURATION_CONVEXITY_DEFINES_SVH
`ifndef SYNTH
`define BPDC_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("bpdc assertion failed");
`define BPDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bpdc assertion failed");
`else
`define BPDC_ASSERT(lbl, clk, rstn, expr)
`define BPDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/bpdc_pkg.sv */
// Shared types, constants and helpers for the bond pricing block.
package bpdc_pkg;

  localparam int MAX_PERIODS_DEF = 64;
  localparam logic [31:0] BASIS_POINT = 32'd429497;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PRICE_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] M32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] DEN_BASE = 64'h0000_0002_0000_0000;

  localparam logic [1:0] REG_FACE = 2'd0;
  localparam logic [1:0] REG_COUPON = 2'd1;
  localparam logic [1:0] REG_PERIODS = 2'd2;

  localparam logic [6:0] K_V = 7'd81;
  localparam logic [6:0] K_MAC = 7'd23;
  localparam logic [6:0] K_MOD = 7'd33;
  localparam logic [6:0] K_CVX = 7'd16;

  typedef enum logic [1:0] {SH_1, SH_17, SH_48} sh_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    sh_t         sh;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [6:0]  k;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] value;
  } unit_rsp_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

endpackage

/* design/bpdc_if.sv */
// Valid/ready channel interfaces for yield requests and results.
interface bpdc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] yield_rate;
  modport source (output valid, output yield_rate, input ready);
  modport sink (input valid, input yield_rate, output ready);
endinterface

interface bpdc_out_if;
  logic               valid;
  logic               ready;
  logic        [47:0] price;
  logic signed [48:0] dv01;
  logic        [31:0] macaulay_years;
  logic        [31:0] modified_years;
  logic        [31:0] convexity;
  logic               overflow;
  modport source (output valid, output price, output dv01, output macaulay_years,
                  output modified_years, output convexity, output overflow, input ready);
  modport sink (input valid, input price, input dv01, input macaulay_years,
                input modified_years, input convexity, input overflow, output ready);
endinterface

/* design/bpdc_mul.sv */
// Rounding, saturating 64x64 multiply built on one 32x32 multiplier.
module bpdc_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpdc_pkg::mul_req_t   req,
  output bpdc_pkg::unit_rsp_t  rsp
);
  import bpdc_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_ADD, M_ROUND} mst_t;

  mst_t         st_r;
  logic [63:0]  a_r, b_r, res_r, prod_r;
  logic [127:0] acc_r;
  sh_t          sh_r;
  logic [1:0]   cnt_r, pidx_r;
  logic         done_r;
  logic [31:0]  a_part, b_part;
  logic [127:0] addend, sum;
  logic [63:0]  rounded;

  assign a_part = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    unique case (pidx_r)
      2'd0: addend = {64'd0, prod_r};
      2'd1, 2'd2: addend = {32'd0, prod_r, 32'd0};
      default: addend = {prod_r, 64'd0};
    endcase
  end

  always_comb begin
    unique case (sh_r)
      SH_1: begin
        sum = acc_r + (128'd1 << 0);
        rounded = (sum[127:65] != '0) ? U64_MAX : sum[64:1];
      end
      SH_17: begin
        sum = acc_r + (128'd1 << 16);
        rounded = (sum[127:81] != '0) ? U64_MAX : sum[80:17];
      end
      default: begin
        sum = acc_r + (128'd1 << 47);
        rounded = (sum[127:112] != '0) ? U64_MAX : sum[111:48];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (req.start) begin
            a_r   <= req.a;
            b_r   <= req.b;
            sh_r  <= req.sh;
            acc_r <= '0;
            cnt_r <= '0;
            st_r  <= M_MUL;
          end
        end
        M_MUL: begin
          prod_r <= 64'(a_part * b_part);
          if (cnt_r != 2'd0) acc_r <= acc_r + addend;
          pidx_r <= cnt_r;
          cnt_r  <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) st_r <= M_ADD;
        end
        M_ADD: begin
          acc_r <= acc_r + addend;
          st_r  <= M_ROUND;
        end
        default: begin
          res_r  <= rounded;
          done_r <= 1'b1;
          st_r   <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp.busy  = (st_r != M_IDLE);
  assign rsp.done  = done_r;
  assign rsp.value = res_r;
endmodule

/* design/bpdc_div.sv */
// Bit-serial rounding divider: round(num * 2^k / den), saturating.
module bpdc_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpdc_pkg::div_req_t   req,
  output bpdc_pkg::unit_rsp_t  rsp
);
  import bpdc_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_LONG, D_FRAC, D_ROUND} dst_t;

  dst_t        st_r;
  logic [63:0] num_r, den_r, q_r, rem_r;
  logic [6:0]  k_r, cnt_r;
  logic        done_r;
  logic [64:0] lr, ldiff;
  logic        lbit, fbit;
  logic [63:0] lrem, fr, frem;

  assign lr    = {rem_r, num_r[63]};
  assign ldiff = lr - {1'b0, den_r};
  assign lbit  = (lr >= {1'b0, den_r});
  assign lrem  = lbit ? ldiff[63:0] : lr[63:0];
  assign fr    = {rem_r[62:0], 1'b0};
  assign fbit  = (fr >= den_r);
  assign frem  = fbit ? (fr - den_r) : fr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (req.start) begin
            num_r <= req.num;
            den_r <= req.den;
            k_r   <= req.k;
            q_r   <= '0;
            rem_r <= '0;
            cnt_r <= '0;
            st_r  <= D_LONG;
          end
        end
        D_LONG: begin
          num_r <= {num_r[62:0], 1'b0};
          rem_r <= lrem;
          q_r   <= {q_r[62:0], lbit};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            cnt_r <= '0;
            st_r  <= D_FRAC;
          end
        end
        D_FRAC: begin
          if (cnt_r == k_r) begin
            st_r <= D_ROUND;
          end else if (q_r[63]) begin
            q_r    <= U64_MAX;
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end else begin
            rem_r <= frem;
            q_r   <= {q_r[62:0], fbit};
            cnt_r <= cnt_r + 7'd1;
          end
        end
        default: begin
          if (fbit && (q_r != U64_MAX)) q_r <= q_r + 64'd1;
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.busy  = (st_r != D_IDLE);
  assign rsp.done  = done_r;
  assign rsp.value = q_r;
endmodule

/* design/bond_price_duration_convexity.sv */
// Semiannual fixed-coupon bond price, DV01, durations and convexity at one yield.
// One yield per transfer; the result leaves through a registered output so the next
// yield is taken while a result waits. Every 64-bit product goes through one 32x32
// multiplier as four partial products, the first pass costs four products per period
// and the shifted-yield pass two, and the discount, duration and convexity quotients
// come from a one-bit-per-cycle divider.
module bond_price_duration_convexity #(
  parameter int MAX_PERIODS = bpdc_pkg::MAX_PERIODS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  bpdc_in_if.sink     in_chan,
  bpdc_out_if.source  out_chan
);
  import bpdc_pkg::*;
  `include "bond_price_duration_convexity_defines.svh"

  localparam int IW = $clog2(MAX_PERIODS + 1);
  localparam int PW = 2 * IW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CPN, S_V, S_PV, S_T1, S_T2, S_D, S_W, S_MAC, S_MOD, S_X, S_CVX, S_DONE
  } st_t;

  st_t         state_r;
  logic        issued_r, pass_r;
  logic [23:0] face_r;
  logic [31:0] coupon_r, y_r;
  logic [6:0]  np_r;
  logic [IW-1:0] i_r, n_r, n_sel;
  logic [63:0] cpn_r, v_r, d_r, pv_r, p_r, s1_r, s2_r, p0_r, v0_r, w_r, x_r;
  logic [31:0] mac_r, mod_r, cvx_r;
  logic        aovf_r;

  logic        out_valid_r, out_ovf_r;
  logic [47:0] out_price_r;
  logic [48:0] out_dv_r;
  logic [31:0] out_mac_r, out_mod_r, out_cvx_r;

  mul_req_t    mreq;
  div_req_t    dreq;
  unit_rsp_t   mrsp, drsp;
  logic        in_xfer, out_free, cfg_wr;
  logic [63:0] cf, den_cur, den0, ii2;
  logic [PW-1:0] iprod;
  logic [63:0] diff, dsat;
  logic        neg, dovf;

  bpdc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  bpdc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FACE:    cfg_prdata = {8'd0, face_r};
      REG_COUPON:  cfg_prdata = coupon_r;
      REG_PERIODS: cfg_prdata = {25'd0, np_r};
      default:     cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (np_r == 7'd0) n_sel = IW'(1);
    else if (32'(np_r) > MAX_PERIODS) n_sel = IW'(MAX_PERIODS);
    else n_sel = IW'(np_r);
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign cf      = (i_r == n_r) ? (cpn_r + {24'd0, face_r, 16'd0}) : cpn_r;
  assign den0    = DEN_BASE + {32'd0, y_r};
  assign den_cur = pass_r ? (den0 + {32'd0, BASIS_POINT}) : den0;
  assign iprod   = PW'(i_r) * (PW'(i_r) + PW'(1));
  assign ii2     = 64'({iprod, 1'b0});

  always_comb begin
    mreq = '{start: 1'b0, a: 64'd0, b: 64'd0, sh: SH_48};
    dreq = '{start: 1'b0, num: 64'd0, k: K_V, den: den_cur};
    unique case (state_r)
      S_CPN: mreq = '{start: !issued_r, a: {40'd0, face_r}, b: {32'd0, coupon_r}, sh: SH_17};
      S_PV:  mreq = '{start: !issued_r, a: cf, b: d_r, sh: SH_48};
      S_T1:  mreq = '{start: !issued_r, a: pv_r, b: 64'({i_r, 1'b0}), sh: SH_1};
      S_T2:  mreq = '{start: !issued_r, a: pv_r, b: ii2, sh: SH_1};
      S_D:   mreq = '{start: !issued_r, a: d_r, b: v_r, sh: SH_48};
      S_W:   mreq = '{start: !issued_r, a: v0_r, b: v0_r, sh: SH_48};
      S_X:   mreq = '{start: !issued_r, a: s2_r, b: w_r, sh: SH_48};
      S_V:   dreq = '{start: !issued_r, num: 64'd1, k: K_V, den: den_cur};
      S_MAC: dreq = '{start: !issued_r, num: s1_r, k: K_MAC, den: p0_r};
      S_MOD: dreq = '{start: !issued_r, num: {32'd0, mac_r}, k: K_MOD, den: den0};
      S_CVX: dreq = '{start: !issued_r, num: x_r, k: K_CVX, den: p0_r};
      default: ;
    endcase
  end

  always_comb begin
    neg  = (p0_r < p_r);
    diff = neg ? (p_r - p0_r) : (p0_r - p_r);
    dovf = (diff > PRICE_MAX);
    dsat = dovf ? PRICE_MAX : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      face_r      <= 24'd1000;
      coupon_r    <= 32'd214748365;
      np_r        <= 7'd20;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_FACE:    face_r   <= cfg_pwdata[23:0];
          REG_COUPON:  coupon_r <= cfg_pwdata;
          REG_PERIODS: np_r     <= cfg_pwdata[6:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      if (mreq.start || dreq.start) issued_r <= 1'b1;
      if (mrsp.done || drsp.done) issued_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            y_r     <= in_chan.yield_rate;
            n_r     <= n_sel;
            pass_r  <= 1'b0;
            state_r <= S_CPN;
          end
        end
        S_CPN: if (mrsp.done) begin
          cpn_r   <= mrsp.value;
          state_r <= S_V;
        end
        S_V: if (drsp.done) begin
          v_r     <= drsp.value;
          d_r     <= drsp.value;
          i_r     <= IW'(1);
          p_r     <= '0;
          if (!pass_r) begin
            s1_r <= '0;
            s2_r <= '0;
          end
          state_r <= S_PV;
        end
        S_PV: if (mrsp.done) begin
          pv_r <= mrsp.value;
          p_r  <= sat_add(p_r, mrsp.value);
          if (!pass_r) begin
            state_r <= S_T1;
          end else if (i_r == n_r) begin
            if (p0_r != 64'd0) begin
              state_r <= S_W;
            end else begin
              mac_r   <= '0;
              mod_r   <= '0;
              cvx_r   <= '0;
              aovf_r  <= 1'b0;
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_D;
          end
        end
        S_T1: if (mrsp.done) begin
          s1_r    <= sat_add(s1_r, mrsp.value);
          state_r <= S_T2;
        end
        S_T2: if (mrsp.done) begin
          s2_r <= sat_add(s2_r, mrsp.value);
          if (i_r == n_r) begin
            p0_r    <= p_r;
            v0_r    <= v_r;
            pass_r  <= 1'b1;
            state_r <= S_V;
          end else begin
            state_r <= S_D;
          end
        end
        S_D: if (mrsp.done) begin
          d_r     <= mrsp.value;
          i_r     <= i_r + IW'(1);
          state_r <= S_PV;
        end
        S_W: if (mrsp.done) begin
          w_r     <= mrsp.value;
          state_r <= S_MAC;
        end
        S_MAC: if (drsp.done) begin
          mac_r   <= (drsp.value > M32) ? 32'hFFFF_FFFF : drsp.value[31:0];
          aovf_r  <= (drsp.value > M32);
          state_r <= S_MOD;
        end
        S_MOD: if (drsp.done) begin
          mod_r   <= (drsp.value > M32) ? 32'hFFFF_FFFF : drsp.value[31:0];
          aovf_r  <= aovf_r || (drsp.value > M32);
          state_r <= S_X;
        end
        S_X: if (mrsp.done) begin
          x_r     <= mrsp.value;
          state_r <= S_CVX;
        end
        S_CVX: if (drsp.done) begin
          cvx_r   <= (drsp.value > M32) ? 32'hFFFF_FFFF : drsp.value[31:0];
          aovf_r  <= aovf_r || (drsp.value > M32);
          state_r <= S_DONE;
        end
        default: begin
          if (out_free) begin
            out_price_r <= (p0_r > PRICE_MAX) ? PRICE_MAX[47:0] : p0_r[47:0];
            out_dv_r    <= neg ? (49'd0 - {1'b0, dsat[47:0]}) : {1'b0, dsat[47:0]};
            out_mac_r   <= mac_r;
            out_mod_r   <= mod_r;
            out_cvx_r   <= cvx_r;
            out_ovf_r   <= aovf_r || dovf || (p0_r > PRICE_MAX);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.price          = out_price_r;
  assign out_chan.dv01           = signed'(out_dv_r);
  assign out_chan.macaulay_years = out_mac_r;
  assign out_chan.modified_years = out_mod_r;
  assign out_chan.convexity      = out_cvx_r;
  assign out_chan.overflow       = out_ovf_r;

  `BPDC_ASSERT(a_mul_idle_start, clk, rst_n, !mreq.start || !mrsp.busy)
  `BPDC_ASSERT(a_div_idle_start, clk, rst_n, !dreq.start || !drsp.busy)
  `BPDC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, state_r != S_IDLE && !in_chan.ready)
  `BPDC_ASSERT(a_mod_le_mac, clk, rst_n, !out_valid_r || (out_mod_r <= out_mac_r))
endmodule
